@@ hdl/rs2i_pkg.sv @@
// Shared types, character codes and limits for the radix string to int64 parser.
`timescale 1ns / 1ps
`default_nettype none

package rs2i_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] LETTER_BASE  = 8'd10;

   localparam logic [5:0] RADIX_AUTO = 6'd0;
   localparam logic [5:0] RADIX_BAD  = 6'd1;
   localparam logic [5:0] RADIX_OCT  = 6'd8;
   localparam logic [5:0] RADIX_DEC  = 6'd10;
   localparam logic [5:0] RADIX_HEX  = 6'd16;
   localparam logic [5:0] RADIX_MAX  = 6'd36;

   localparam logic [5:0] RADIX_RESET  = RADIX_DEC;
   localparam logic       SIGNED_RESET = 1'b1;

   localparam logic REG_RADIX  = 1'b0;
   localparam logic REG_SIGNED = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_RADIX = 2'd2;

   localparam logic [63:0] LIMIT_SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIMIT_SMIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] LIMIT_UMAX = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int MAX_STRING_LEN = 4096;
   localparam int OFF_W          = $clog2(MAX_STRING_LEN + 1);

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       last;
      logic       is_digit;
      logic [5:0] digit;
      logic       is_nul;
      logic       is_space;
      logic       is_minus;
      logic       is_plus;
      logic       is_zero;
      logic       is_x;
   } item_type;

   function automatic logic [63:0] limit_of(input logic signed_mode, input logic negative);
      logic [63:0] lim;
      if (signed_mode) begin
         lim = negative ? LIMIT_SMIN : LIMIT_SMAX;
      end else begin
         lim = LIMIT_UMAX;
      end
      return lim;
   endfunction

endpackage

`default_nettype wire

@@ hdl/rs2i_if.sv @@
// Valid/ready channel interfaces for characters in and parse results out.
`timescale 1ns / 1ps
`default_nettype none

interface rs2i_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rs2i_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [63:0]                 value;
   logic [rs2i_pkg::OFF_W-1:0]  end_offset;
   logic [1:0]                  status;

   modport source (output valid, output value, output end_offset, output status, input ready);
   modport sink   (input valid, input value, input end_offset, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/radix_string_to_int64.sv @@
// Top level of the character-serial radix string to 64-bit integer parser.
`timescale 1ns / 1ps
`default_nettype none

// Parses an integer in radix 2..36 or auto radix, skipping leading whitespace and an
// optional sign, clamping to the signed or unsigned 64-bit limits on overflow. Each
// character passes the accumulate stage with its single 64x6 multiply, add and limit
// compare; the result for a string is registered in the finish and then the result
// stage once its last character is taken, and a new character is taken every cycle
// while the result channel keeps up. Registers: radix at byte address 0, signed_mode
// at byte address 4; write them only while the parser is idle. Character positions
// and end_offset saturate at MAX_STRING_LEN from the package.
module radix_string_to_int64 (
   input  wire logic        clock,
   input  wire logic        reset,
   rs2i_req_if.sink         req,
   rs2i_rsp_if.source       rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [5:0]         radix_ff;
   logic               signed_ff;
   logic               csr_write;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   rs2i_pkg::item_type front_item;
   rs2i_pkg::item_type back_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == rs2i_pkg::REG_SIGNED) ? {31'd0, signed_ff}
                                                        : {26'd0, radix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= rs2i_pkg::RADIX_RESET;
         signed_ff <= rs2i_pkg::SIGNED_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            rs2i_pkg::REG_RADIX:  radix_ff  <= pwdata[5:0];
            rs2i_pkg::REG_SIGNED: signed_ff <= pwdata[0];
            default:              radix_ff  <= radix_ff;
         endcase
      end
   end

   rs2i_front u_front (
      .req    (req),
      .q_full (q_full),
      .push   (q_push),
      .item   (front_item)
   );

   rs2i_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_item  (front_item),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .full     (q_full),
      .rd_item  (back_item)
   );

   rs2i_back u_back (
      .clock       (clock),
      .reset       (reset),
      .radix       (radix_ff),
      .signed_mode (signed_ff),
      .q_valid     (q_valid),
      .item        (back_item),
      .pop         (q_pop),
      .rsp         (rsp)
   );

endmodule

`default_nettype wire

@@ hdl/rs2i_front.sv @@
// Front end: takes character transfers and classifies each character for the parser.
`timescale 1ns / 1ps
`default_nettype none

module rs2i_front (
   rs2i_req_if.sink           req,
   input  wire logic          q_full,
   output logic               push,
   output rs2i_pkg::item_type item
);

   logic [7:0] c;

   assign c         = req.char_code;
   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   always_comb begin
      item          = '0;
      item.last     = req.last_char;
      item.is_nul   = (c == rs2i_pkg::CHAR_NUL);
      item.is_space = (c == rs2i_pkg::CHAR_SPACE) ||
                      ((c >= rs2i_pkg::CHAR_TAB) && (c <= rs2i_pkg::CHAR_CR));
      item.is_minus = (c == rs2i_pkg::CHAR_MINUS);
      item.is_plus  = (c == rs2i_pkg::CHAR_PLUS);
      item.is_zero  = (c == rs2i_pkg::CHAR_ZERO);
      item.is_x     = (c == rs2i_pkg::CHAR_LOWER_X) || (c == rs2i_pkg::CHAR_UPPER_X);
      if ((c >= rs2i_pkg::CHAR_ZERO) && (c <= rs2i_pkg::CHAR_NINE)) begin
         item.is_digit = 1'b1;
         item.digit    = 6'(c - rs2i_pkg::CHAR_ZERO);
      end else if ((c >= rs2i_pkg::CHAR_UPPER_A) && (c <= rs2i_pkg::CHAR_UPPER_Z)) begin
         item.is_digit = 1'b1;
         item.digit    = 6'(c - rs2i_pkg::CHAR_UPPER_A + rs2i_pkg::LETTER_BASE);
      end else if ((c >= rs2i_pkg::CHAR_LOWER_A) && (c <= rs2i_pkg::CHAR_LOWER_Z)) begin
         item.is_digit = 1'b1;
         item.digit    = 6'(c - rs2i_pkg::CHAR_LOWER_A + rs2i_pkg::LETTER_BASE);
      end
   end

endmodule

`default_nettype wire

@@ hdl/rs2i_queue.sv @@
// Short register queue between the classifier and the accumulate stage.
`timescale 1ns / 1ps
`default_nettype none

module rs2i_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rs2i_pkg::item_type wr_item,
   input  wire logic               pop,
   output logic                    rd_valid,
   output logic                    full,
   output rs2i_pkg::item_type      rd_item
);

   localparam int PtrW = $clog2(rs2i_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(rs2i_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntW-1:0] Depth = CntW'(rs2i_pkg::QUEUE_DEPTH);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(rs2i_pkg::QUEUE_DEPTH - 1);

   rs2i_pkg::item_type slot_ff [rs2i_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign rd_valid = (count_ff != '0);
   assign full     = (count_ff == Depth);
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

@@ hdl/rs2i_back.sv @@
// Back end: parse state machine, digit accumulate with overflow check, result stages.
`timescale 1ns / 1ps
`default_nettype none

module rs2i_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [5:0]         radix,
   input  wire logic               signed_mode,
   input  wire logic               q_valid,
   input  wire rs2i_pkg::item_type item,
   output logic                    pop,
   rs2i_rsp_if.source              rsp
);

   localparam int OffW = rs2i_pkg::OFF_W;
   localparam logic [OffW-1:0] MaxLen = OffW'(rs2i_pkg::MAX_STRING_LEN);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_PENDX,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [63:0]     acc_ff, acc_in;
   logic            neg_ff, neg_in;
   logic            ovf_ff, ovf_in;
   logic [5:0]      eff_ff, eff_in;
   logic [OffW-1:0] idx_ff, idx_in;
   logic [OffW-1:0] end_ff, end_in;

   logic            fin_valid_ff;
   logic [63:0]     fin_acc_ff;
   logic            fin_neg_ff;
   logic            fin_ovf_ff;
   logic            fin_bad_ff;
   logic [OffW-1:0] fin_end_ff;

   logic            rsp_valid_ff;
   logic [63:0]     rsp_value_ff, rsp_value_in;
   logic [OffW-1:0] rsp_off_ff, rsp_off_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   logic            advance;
   logic            radix_auto;
   logic            radix_hex;
   logic            radix_bad;
   logic            take;
   logic            accept_digit;
   logic [5:0]      eff_use;
   logic [5:0]      start_radix;
   logic [5:0]      zero_radix;
   logic [69:0]     prod;
   logic [70:0]     sum;
   logic            over;
   logic [OffW-1:0] idx_sat;

   assign advance     = !rsp_valid_ff || rsp.ready;
   assign pop         = q_valid && advance;
   assign radix_auto  = (radix == rs2i_pkg::RADIX_AUTO);
   assign radix_hex   = (radix == rs2i_pkg::RADIX_HEX);
   assign radix_bad   = (radix == rs2i_pkg::RADIX_BAD) || (radix > rs2i_pkg::RADIX_MAX);
   assign start_radix = radix_auto ? rs2i_pkg::RADIX_DEC : radix;
   assign zero_radix  = radix_auto ? rs2i_pkg::RADIX_OCT : rs2i_pkg::RADIX_HEX;
   assign idx_sat     = (idx_ff >= MaxLen) ? MaxLen : idx_ff + 1'b1;

   always_comb begin
      take    = 1'b0;
      eff_use = eff_ff;
      case (phase_ff)
         PH_SPACE: begin
            if (!item.is_nul && !item.is_space && !item.is_minus && !item.is_plus &&
                !item.is_zero) begin
               take    = 1'b1;
               eff_use = start_radix;
            end
         end
         PH_SIGN: begin
            if (!item.is_zero) begin
               take    = 1'b1;
               eff_use = start_radix;
            end
         end
         PH_ZERO: begin
            if (!item.is_x) begin
               take    = 1'b1;
               eff_use = zero_radix;
            end
         end
         PH_PENDX: begin
            if (item.is_digit && (item.digit < rs2i_pkg::RADIX_HEX)) begin
               take    = 1'b1;
               eff_use = rs2i_pkg::RADIX_HEX;
            end
         end
         PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   assign accept_digit = take && item.is_digit && (item.digit < eff_use);
   assign prod = 70'(acc_ff) * 70'(eff_use);
   assign sum  = 71'(prod) + 71'(item.digit);
   assign over = (sum > 71'(rs2i_pkg::limit_of(signed_mode, neg_ff)));

   always_comb begin
      logic start_num;
      start_num = 1'b0;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      eff_in    = eff_ff;
      end_in    = end_ff;
      idx_in    = idx_sat;
      case (phase_ff)
         PH_SPACE: begin
            if (item.is_nul) begin
               phase_in = PH_DONE;
            end else if (item.is_space) begin
               phase_in = PH_SPACE;
            end else if (item.is_minus) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGN;
            end else if (item.is_plus) begin
               phase_in = PH_SIGN;
            end else begin
               start_num = 1'b1;
            end
         end
         PH_SIGN: begin
            start_num = 1'b1;
         end
         PH_ZERO: begin
            if (item.is_x) begin
               phase_in = PH_PENDX;
            end else begin
               eff_in   = eff_use;
               phase_in = PH_DIGITS;
            end
         end
         PH_PENDX: begin
            if (take) begin
               eff_in   = eff_use;
               phase_in = PH_DIGITS;
            end else begin
               eff_in   = zero_radix;
               phase_in = PH_DONE;
            end
         end
         PH_DIGITS: begin
            phase_in = PH_DIGITS;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      if (start_num) begin
         if (item.is_zero) begin
            end_in = idx_sat;
            if (radix_auto || radix_hex) begin
               phase_in = PH_ZERO;
            end else begin
               eff_in   = radix;
               phase_in = PH_DIGITS;
            end
         end else begin
            eff_in   = eff_use;
            phase_in = PH_DIGITS;
         end
      end
      if (take) begin
         if (accept_digit) begin
            if (!ovf_ff) begin
               if (over) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = sum[63:0];
               end
            end
            end_in = idx_sat;
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   always_comb begin
      rsp_off_in = fin_end_ff;
      if (fin_bad_ff) begin
         rsp_value_in  = '0;
         rsp_off_in    = '0;
         rsp_status_in = rs2i_pkg::STATUS_RADIX;
      end else if (fin_ovf_ff) begin
         rsp_value_in  = rs2i_pkg::limit_of(signed_mode, fin_neg_ff);
         rsp_status_in = rs2i_pkg::STATUS_RANGE;
      end else begin
         rsp_value_in  = fin_neg_ff ? (64'd0 - fin_acc_ff) : fin_acc_ff;
         rsp_status_in = rs2i_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         eff_ff       <= '0;
         idx_ff       <= '0;
         end_ff       <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (item.last) begin
               phase_ff <= PH_SPACE;
               acc_ff   <= '0;
               neg_ff   <= 1'b0;
               ovf_ff   <= 1'b0;
               eff_ff   <= '0;
               idx_ff   <= '0;
               end_ff   <= '0;
            end else begin
               phase_ff <= phase_in;
               acc_ff   <= acc_in;
               neg_ff   <= neg_in;
               ovf_ff   <= ovf_in;
               eff_ff   <= eff_in;
               idx_ff   <= idx_in;
               end_ff   <= end_in;
            end
         end
         if (advance) begin
            fin_valid_ff <= pop && item.last;
            if (pop && item.last) begin
               fin_acc_ff <= acc_in;
               fin_neg_ff <= neg_in;
               fin_ovf_ff <= ovf_in;
               fin_end_ff <= end_in;
               fin_bad_ff <= radix_bad;
            end
            rsp_valid_ff <= fin_valid_ff;
            if (fin_valid_ff) begin
               rsp_value_ff  <= rsp_value_in;
               rsp_off_ff    <= rsp_off_in;
               rsp_status_ff <= rsp_status_in;
            end
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.value      = rsp_value_ff;
   assign rsp.end_offset = rsp_off_ff;
   assign rsp.status     = rsp_status_ff;

endmodule

`default_nettype wire

@@ hdl/rs2i_checker.sv @@
// Port-level checks on the parser's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rs2i_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_value,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_off_zero
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_bad_radix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rs2i_pkg::STATUS_RADIX) |-> (rsp_value == 64'd0) &&
      rsp_off_zero)
      else $error("invalid radix result carries data");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rs2i_pkg::STATUS_RANGE) |->
      (rsp_value == rs2i_pkg::LIMIT_SMAX) || (rsp_value == rs2i_pkg::LIMIT_SMIN) ||
      (rsp_value == rs2i_pkg::LIMIT_UMAX))
      else $error("out of range result is not a limit");

endmodule

bind radix_string_to_int64 rs2i_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_value    (rsp.value),
   .rsp_status   (rsp.status),
   .rsp_off_zero (rsp.end_offset == '0)
);

`default_nettype wire

@@ sim/radix_string_to_int64_tb.sv @@
// Self-checking testbench for radix_string_to_int64: a shadow parser predicts each result.
`timescale 1ns / 1ps

typedef enum logic [2:0] {
   SCAN_SPACE,
   SCAN_SIGN,
   SCAN_ZERO,
   SCAN_PREFIX,
   SCAN_DIGITS,
   SCAN_DONE
} scan_phase_type;

typedef logic [rs2i_pkg::OFF_W-1:0] offset_type;

typedef struct packed {
   logic [63:0] value;
   offset_type  end_offset;
   logic [1:0]  status;
} parse_result_type;

class parse_scoreboard;
   logic [5:0]       radix_reg;
   logic             signed_reg;
   scan_phase_type   scan;
   logic [63:0]      acc;
   logic             negative;
   logic             overflow;
   logic [5:0]       base;
   int unsigned      char_pos;
   int unsigned      number_end;
   parse_result_type expected_q[$];
   int               errors;

   function new();
      radix_reg  = rs2i_pkg::RADIX_RESET;
      signed_reg = rs2i_pkg::SIGNED_RESET;
      errors     = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      scan       = SCAN_SPACE;
      acc        = '0;
      negative   = 1'b0;
      overflow   = 1'b0;
      base       = '0;
      char_pos   = 0;
      number_end = 0;
   endfunction

   function int unsigned bump(int unsigned x);
      return (x >= rs2i_pkg::MAX_STRING_LEN) ? rs2i_pkg::MAX_STRING_LEN : x + 1;
   endfunction

   function int unsigned digit_of(logic [7:0] c);
      if (c >= rs2i_pkg::CHAR_ZERO && c <= rs2i_pkg::CHAR_NINE)
         return 32'(c - rs2i_pkg::CHAR_ZERO);
      if (c >= rs2i_pkg::CHAR_UPPER_A && c <= rs2i_pkg::CHAR_UPPER_Z)
         return 32'(c - rs2i_pkg::CHAR_UPPER_A + rs2i_pkg::LETTER_BASE);
      if (c >= rs2i_pkg::CHAR_LOWER_A && c <= rs2i_pkg::CHAR_LOWER_Z)
         return 32'(c - rs2i_pkg::CHAR_LOWER_A + rs2i_pkg::LETTER_BASE);
      return 64;
   endfunction

   function logic [63:0] clamp_limit();
      if (signed_reg) return negative ? rs2i_pkg::LIMIT_SMIN : rs2i_pkg::LIMIT_SMAX;
      return rs2i_pkg::LIMIT_UMAX;
   endfunction

   function void take_digit(logic [7:0] c);
      int unsigned d;
      logic [71:0] wide;
      d = digit_of(c);
      if (d >= 32'(base)) begin
         scan = SCAN_DONE;
         return;
      end
      if (!overflow) begin
         wide = 72'(acc) * 72'(base) + 72'(d);
         if (wide > 72'(clamp_limit())) overflow = 1'b1;
         else acc = wide[63:0];
      end
      number_end = bump(char_pos);
   endfunction

   function void start_number(logic [7:0] c);
      if (c == rs2i_pkg::CHAR_ZERO) begin
         number_end = bump(char_pos);
         if (radix_reg == rs2i_pkg::RADIX_AUTO || radix_reg == rs2i_pkg::RADIX_HEX) begin
            scan = SCAN_ZERO;
         end else begin
            base = radix_reg;
            scan = SCAN_DIGITS;
         end
         return;
      end
      base = (radix_reg == rs2i_pkg::RADIX_AUTO) ? rs2i_pkg::RADIX_DEC : radix_reg;
      scan = SCAN_DIGITS;
      take_digit(c);
   endfunction

   function void advance(logic [7:0] c);
      case (scan)
         SCAN_SPACE: begin
            if (c == rs2i_pkg::CHAR_NUL) scan = SCAN_DONE;
            else if (c == rs2i_pkg::CHAR_SPACE ||
                     (c >= rs2i_pkg::CHAR_TAB && c <= rs2i_pkg::CHAR_CR)) scan = SCAN_SPACE;
            else if (c == rs2i_pkg::CHAR_MINUS) begin
               negative = 1'b1;
               scan = SCAN_SIGN;
            end else if (c == rs2i_pkg::CHAR_PLUS) scan = SCAN_SIGN;
            else start_number(c);
         end
         SCAN_SIGN: start_number(c);
         SCAN_ZERO: begin
            if (c == rs2i_pkg::CHAR_LOWER_X || c == rs2i_pkg::CHAR_UPPER_X) begin
               scan = SCAN_PREFIX;
            end else begin
               base = (radix_reg == rs2i_pkg::RADIX_AUTO) ? rs2i_pkg::RADIX_OCT
                                                          : rs2i_pkg::RADIX_HEX;
               scan = SCAN_DIGITS;
               take_digit(c);
            end
         end
         SCAN_PREFIX: begin
            base = (radix_reg == rs2i_pkg::RADIX_AUTO) ? rs2i_pkg::RADIX_OCT
                                                       : rs2i_pkg::RADIX_HEX;
            if (digit_of(c) < 32'(rs2i_pkg::RADIX_HEX)) begin
               base = rs2i_pkg::RADIX_HEX;
               scan = SCAN_DIGITS;
               take_digit(c);
            end else begin
               scan = SCAN_DONE;
            end
         end
         SCAN_DIGITS: take_digit(c);
         default: scan = SCAN_DONE;
      endcase
   endfunction

   function void note_char(logic [7:0] c, logic last);
      parse_result_type r;
      advance(c);
      char_pos = bump(char_pos);
      if (!last) return;
      advance(rs2i_pkg::CHAR_NUL);
      if (radix_reg == rs2i_pkg::RADIX_BAD || radix_reg > rs2i_pkg::RADIX_MAX) begin
         r = '{64'd0, '0, rs2i_pkg::STATUS_RADIX};
      end else if (overflow) begin
         r = '{clamp_limit(), offset_type'(number_end), rs2i_pkg::STATUS_RANGE};
      end else begin
         r = '{negative ? 64'd0 - acc : acc, offset_type'(number_end), rs2i_pkg::STATUS_OK};
      end
      expected_q.push_back(r);
      clear_parse();
   endfunction

   function void set_register(logic idx, logic [31:0] data);
      if (idx == rs2i_pkg::REG_RADIX) radix_reg = data[5:0];
      else signed_reg = data[0];
   endfunction

   function logic [31:0] register_value(logic idx);
      return (idx == rs2i_pkg::REG_RADIX) ? {26'd0, radix_reg} : {31'd0, signed_reg};
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_result(parse_result_type got);
      parse_result_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("result with none pending: value=%h end_offset=%0d status=%0d",
                          got.value, got.end_offset, got.status));
         return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value)
         report($sformatf("value %h, expected %h", got.value, want.value));
      if (got.end_offset !== want.end_offset)
         report($sformatf("end_offset %0d, expected %0d", got.end_offset, want.end_offset));
      if (got.status !== want.status)
         report($sformatf("status %0d, expected %0d", got.status, want.status));
   endtask
endclass

module radix_string_to_int64_tb;
   localparam int   CYCLE_LIMIT   = 1_000_000;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   SEGMENT_ITEMS = 130;
   localparam int   HOLD_CYCLES   = 300;
   localparam logic CSR_WRITE     = 1'b1;
   localparam logic CSR_READ      = 1'b0;

   typedef logic [7:0] text_type[$];

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int hold_left      = 0;
   int cycle_count    = 0;

   parse_scoreboard board;

   rs2i_req_if req_ch ();
   rs2i_rsp_if rsp_ch ();

   radix_string_to_int64 uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("radix_string_to_int64 regression: fail");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(parse_result_type'({rsp_ch.value, rsp_ch.end_offset,
                                                rsp_ch.status}));
   end

   function automatic text_type text_of(string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   function automatic logic [7:0] digit_char(int unsigned d);
      if (d < 32'(rs2i_pkg::LETTER_BASE)) return 8'(rs2i_pkg::CHAR_ZERO + d);
      return 8'(($urandom_range(1) ? rs2i_pkg::CHAR_UPPER_A : rs2i_pkg::CHAR_LOWER_A) + d
                - rs2i_pkg::LETTER_BASE);
   endfunction

   function automatic logic [7:0] space_char();
      logic [7:0] w;
      w = 8'($urandom_range(rs2i_pkg::CHAR_TAB, rs2i_pkg::CHAR_CR + 1));
      return (w > rs2i_pkg::CHAR_CR) ? rs2i_pkg::CHAR_SPACE : w;
   endfunction

   function automatic text_type render(logic [71:0] v, int unsigned b);
      text_type t;
      if (v == 0) t.push_back(rs2i_pkg::CHAR_ZERO);
      while (v != 0) begin
         t.push_front(digit_char(32'(v % b)));
         v = v / b;
      end
      return t;
   endfunction

   function automatic text_type make_string(logic [5:0] radix_now);
      text_type t;
      text_type body;
      int unsigned b;
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(255)));
         return t;
      end
      repeat ($urandom_range(2)) t.push_back(space_char());
      case ($urandom_range(3))
         0: t.push_back(rs2i_pkg::CHAR_MINUS);
         1: t.push_back(rs2i_pkg::CHAR_PLUS);
         default: ;
      endcase
      if (radix_now == rs2i_pkg::RADIX_BAD || radix_now > rs2i_pkg::RADIX_MAX) begin
         b = $urandom_range(2, rs2i_pkg::RADIX_MAX);
      end else if (radix_now == rs2i_pkg::RADIX_AUTO || radix_now == rs2i_pkg::RADIX_HEX) begin
         case ($urandom_range(3))
            0: begin
               t.push_back(rs2i_pkg::CHAR_ZERO);
               t.push_back($urandom_range(1) ? rs2i_pkg::CHAR_LOWER_X
                                             : rs2i_pkg::CHAR_UPPER_X);
               b = 32'(rs2i_pkg::RADIX_HEX);
            end
            1: begin
               t.push_back(rs2i_pkg::CHAR_ZERO);
               b = (radix_now == rs2i_pkg::RADIX_AUTO) ? 32'(rs2i_pkg::RADIX_OCT)
                                                       : 32'(rs2i_pkg::RADIX_HEX);
            end
            default: b = (radix_now == rs2i_pkg::RADIX_AUTO) ? 32'(rs2i_pkg::RADIX_DEC)
                                                             : 32'(rs2i_pkg::RADIX_HEX);
         endcase
      end else begin
         b = 32'(radix_now);
      end
      case ($urandom_range(9))
         0: ;
         1: body = render({8'd0, rs2i_pkg::LIMIT_SMAX} + 72'($urandom_range(2)) - 72'd1, b);
         2: body = render({8'd0, rs2i_pkg::LIMIT_UMAX} + 72'($urandom_range(2)) - 72'd1, b);
         3: repeat ($urandom_range(15, 70)) body.push_back(digit_char($urandom_range(b - 1)));
         default: repeat ($urandom_range(1, 8)) body.push_back(digit_char($urandom_range(b - 1)));
      endcase
      t = {t, body};
      case ($urandom_range(5))
         0: begin
            t.push_back(rs2i_pkg::CHAR_NUL);
            t.push_back(8'($urandom_range(255)));
         end
         1: t.push_back(8'($urandom_range(255)));
         2: t.push_back(rs2i_pkg::CHAR_LOWER_X);
         default: ;
      endcase
      if (t.size() == 0) t.push_back(8'($urandom_range(255)));
      return t;
   endfunction

   task automatic send_char(logic [7:0] c, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid     <= 1'b0;
         req_ch.char_code <= 8'($urandom_range(255));
         req_ch.last_char <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.last_char <= last;
      do @(posedge clock); while (!req_ch.ready);
      board.note_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_text(text_type text);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic csr_access(logic write, logic idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (write) begin
         board.set_register(idx, data);
      end else if (prdata !== board.register_value(idx)) begin
         board.report($sformatf("register %0d reads %h, expected %h",
                                idx, prdata, board.register_value(idx)));
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [5:0] radix_value, logic signed_value);
      logic [31:0] w;
      settle();
      w = $urandom();
      w[5:0] = radix_value;
      csr_access(CSR_WRITE, rs2i_pkg::REG_RADIX, w);
      w = $urandom();
      w[0] = signed_value;
      csr_access(CSR_WRITE, rs2i_pkg::REG_SIGNED, w);
      csr_access(CSR_READ, rs2i_pkg::REG_RADIX, 32'd0);
      csr_access(CSR_READ, rs2i_pkg::REG_SIGNED, 32'd0);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [5:0]  radix_plan [12];
      int unsigned sent;
      text_type    t;
      board = new();
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.last_char = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      csr_access(CSR_READ, rs2i_pkg::REG_RADIX, 32'd0);
      csr_access(CSR_READ, rs2i_pkg::REG_SIGNED, 32'd0);
      psel    <= 1'b0;
      penable <= 1'b0;

      // empty string, junk after a number, sign with no digits
      send_char(rs2i_pkg::CHAR_NUL, 1'b1);
      t = text_of("-7");
      t.push_back(8'hFF);
      t.push_back(8'(rs2i_pkg::CHAR_ZERO + 5));
      send_text(t);
      t = text_of("+");
      t.push_back(rs2i_pkg::CHAR_TAB);
      send_text(t);
      // hex prefix with no hex digit after it, then a string under an invalid radix
      configure(rs2i_pkg::RADIX_AUTO, 1'b1);
      send_text(text_of("0xg"));
      configure(rs2i_pkg::RADIX_BAD, 1'b0);
      send_text(text_of("5"));
      // negative overflow clamps to the signed minimum
      configure(rs2i_pkg::RADIX_MAX, 1'b1);
      send_text(text_of("-zzzzzzzzzzzzz"));

      radix_plan = '{rs2i_pkg::RADIX_AUTO, 6'd2, rs2i_pkg::RADIX_MAX, rs2i_pkg::RADIX_HEX,
                     6'd63, rs2i_pkg::RADIX_OCT, rs2i_pkg::RADIX_DEC, rs2i_pkg::RADIX_BAD,
                     rs2i_pkg::RADIX_AUTO, rs2i_pkg::RADIX_HEX, 6'd37, 6'd0};
      radix_plan[11] = 6'($urandom_range(2, rs2i_pkg::RADIX_MAX));
      for (int seg = 0; seg < 12; seg++) begin
         case (seg / 3)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         configure(radix_plan[seg], seg % 2 == 0);
         // stall the result side while characters keep coming
         if (seg == 0) hold_request = HOLD_CYCLES;
         sent = 0;
         while (sent < SEGMENT_ITEMS) begin
            t = make_string(radix_plan[seg]);
            send_text(t);
            sent += t.size();
         end
      end

      settle();
      if (board.errors == 0) begin
         $display("radix_string_to_int64 regression: pass");
      end else begin
         $display("radix_string_to_int64 regression: fail");
      end
      $finish;
   end
endmodule
